FILE: rtl/core/dscd_pkg.sv
package dscd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_CLICK = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_CLICK = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_COOLDOWN  = 2'd3;

  localparam logic [CfgW-1:0] DEBOUNCE_RST  = 16'd30;
  localparam logic [CfgW-1:0] MIN_CLICK_RST = 16'd30;
  localparam logic [CfgW-1:0] MAX_CLICK_RST = 16'd1000;
  localparam logic [CfgW-1:0] COOLDOWN_RST  = 16'd300;

  typedef struct packed {
    logic [CfgW-1:0] debounce_time;
    logic [CfgW-1:0] min_click_time;
    logic [CfgW-1:0] max_click_time;
    logic [CfgW-1:0] cooldown_time;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             raw_pressed;
    logic             take_click;
  } in_beat_t;

  typedef struct packed {
    logic click;
    logic stable_pressed;
  } out_beat_t;

  typedef struct packed {
    logic             started;
    logic             raw_level;
    logic             stable_level;
    logic             ignore_next_release;
    logic [TimeW-1:0] raw_change_time;
    logic [TimeW-1:0] press_start_time;
    logic [TimeW-1:0] last_click_time;
    logic             click_pending;
    logic             click_seen;
  } state_t;

endpackage

FILE: rtl/core/dscd_in_if.sv
interface dscd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        raw_pressed;
  logic        take_click;

  modport source (output valid, output now_ms, output raw_pressed, output take_click,
                  input ready);
  modport sink (input valid, input now_ms, input raw_pressed, input take_click,
                output ready);
endinterface

FILE: rtl/core/dscd_out_if.sv
interface dscd_out_if;
  logic valid;
  logic ready;
  logic click;
  logic stable_pressed;

  modport source (output valid, output click, output stable_pressed, input ready);
  modport sink (input valid, input click, input stable_pressed, output ready);
endinterface

FILE: rtl/core/dscd_step.sv
module dscd_step (
  input  dscd_pkg::cfg_t     cfg,
  input  dscd_pkg::state_t   st,
  input  dscd_pkg::in_beat_t beat,
  output dscd_pkg::state_t   st_nxt,
  output dscd_pkg::out_beat_t res
);

  logic                         raw_chg;
  logic [dscd_pkg::TimeW-1:0]   eff_change;
  logic [dscd_pkg::TimeW-1:0]   since_change;
  logic [dscd_pkg::TimeW-1:0]   held;
  logic [dscd_pkg::TimeW-1:0]   since_click;
  logic                         settled;
  logic                         in_window;
  logic                         cooling;
  logic                         clicked;

  always_comb begin
    raw_chg      = beat.raw_pressed != st.raw_level;
    eff_change   = raw_chg ? beat.now_ms : st.raw_change_time;
    since_change = beat.now_ms - eff_change;
    held         = beat.now_ms - st.press_start_time;
    since_click  = beat.now_ms - st.last_click_time;
    settled      = since_change >= {16'd0, cfg.debounce_time};
    in_window    = (held >= {16'd0, cfg.min_click_time}) &&
                   (held <= {16'd0, cfg.max_click_time});
    cooling      = st.click_seen && (since_click < {16'd0, cfg.cooldown_time});

    st_nxt = st;
    if (!st.started) begin
      st_nxt.started             = 1'b1;
      st_nxt.raw_level           = beat.raw_pressed;
      st_nxt.stable_level        = beat.raw_pressed;
      st_nxt.ignore_next_release = beat.raw_pressed;
      st_nxt.raw_change_time     = beat.now_ms;
      st_nxt.press_start_time    = beat.raw_pressed ? beat.now_ms : '0;
      st_nxt.last_click_time     = '0;
      st_nxt.click_seen          = 1'b0;
      st_nxt.click_pending       = 1'b0;
    end else begin
      st_nxt.raw_level       = beat.raw_pressed;
      st_nxt.raw_change_time = eff_change;
      if ((beat.raw_pressed != st.stable_level) && settled) begin
        st_nxt.stable_level = beat.raw_pressed;
        if (beat.raw_pressed) begin
          st_nxt.press_start_time = beat.now_ms;
        end else if (st.ignore_next_release) begin
          st_nxt.ignore_next_release = 1'b0;
        end else if (in_window && !cooling) begin
          st_nxt.last_click_time = beat.now_ms;
          st_nxt.click_seen      = 1'b1;
          st_nxt.click_pending   = 1'b1;
        end
      end
    end

    clicked = 1'b0;
    if (beat.take_click) begin
      clicked              = st_nxt.click_pending;
      st_nxt.click_pending = 1'b0;
    end

    res.click          = clicked;
    res.stable_pressed = st_nxt.stable_level;
  end

endmodule

FILE: rtl/core/debounced_short_click_detector.sv
// Button debouncer and short-click detector. Each input beat (timestamp in ms, raw level,
// take flag) yields exactly one result beat (click taken, debounced level). A beat is
// registered on entry, the whole debounce and click decision is made from that register
// and the state registers, and the result sits in an output register. One beat is
// accepted every cycle while the output side keeps up. The limit is the single
// state-update stage, which closes on itself each cycle. Configuration writes take
// effect at once and are meant for idle periods only.
module debounced_short_click_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  dscd_in_if.sink                          in_ch,
  dscd_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [dscd_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [dscd_pkg::CfgW-1:0]        cfg_data
);

  dscd_pkg::cfg_t      cfg_r;
  dscd_pkg::state_t    st_r;
  dscd_pkg::state_t    st_nxt;
  dscd_pkg::in_beat_t  in_beat_r;
  dscd_pkg::out_beat_t res_nxt;
  dscd_pkg::out_beat_t res_r;
  logic                in_v_r;
  logic                out_v_r;
  logic                proc;

  assign proc         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || proc;
  assign out_ch.valid = out_v_r;
  assign out_ch.click = res_r.click;
  assign out_ch.stable_pressed = res_r.stable_pressed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time  <= dscd_pkg::DEBOUNCE_RST;
      cfg_r.min_click_time <= dscd_pkg::MIN_CLICK_RST;
      cfg_r.max_click_time <= dscd_pkg::MAX_CLICK_RST;
      cfg_r.cooldown_time  <= dscd_pkg::COOLDOWN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dscd_pkg::REG_DEBOUNCE:  cfg_r.debounce_time  <= cfg_data;
        dscd_pkg::REG_MIN_CLICK: cfg_r.min_click_time <= cfg_data;
        dscd_pkg::REG_MAX_CLICK: cfg_r.max_click_time <= cfg_data;
        dscd_pkg::REG_COOLDOWN:  cfg_r.cooldown_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_beat_r.now_ms      <= in_ch.now_ms;
      in_beat_r.raw_pressed <= in_ch.raw_pressed;
      in_beat_r.take_click  <= in_ch.take_click;
    end
  end

  dscd_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .beat   (in_beat_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  a_first_beat_no_click: assert property (@(posedge clk) disable iff (!rst_n)
    proc && !st_r.started |=> !res_r.click)
    else $error("click reported on first beat");

  a_pending_has_seen: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.click_pending |-> st_r.click_seen)
    else $error("pending click without recorded click time");

  a_ignore_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.ignore_next_release |-> st_r.started)
    else $error("release ignore flag set before start");

  a_proc_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> out_v_r)
    else $error("processed beat lost before output");
`endif

endmodule
